>>> design/pssel_pkg.sv
// Shared types and constants for the proportional subframe slice selector.
// Used by pssel_div, pssel_ctrl and proportional_subframe_slice_selector_core.
package pssel_pkg;

	localparam int NUM_SLICES  = 4;
	localparam int SHARE_BITS  = 8;
	localparam int PERIOD_BITS = 8;
	localparam int SF_BITS     = 14;
	localparam int STATUS_W    = 2;
	localparam int SLICE_W     = 2;

	// slice counter, and a count wide enough for the sum of all reduced shares
	localparam int IDX_W = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
	localparam int CNT_W = SHARE_BITS + $clog2(NUM_SLICES);

	// shared divider: numerator covers subframe numbers and shares
	localparam int DIV_D_W   = (SHARE_BITS > PERIOD_BITS) ? SHARE_BITS : PERIOD_BITS;
	localparam int DIV_N_W   = (SF_BITS > DIV_D_W) ? SF_BITS : DIV_D_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	// configuration port
	localparam int CFG_IDX_W  = $clog2(NUM_SLICES + 2);
	localparam int CFG_DATA_W = DIV_D_W;

	typedef logic [SHARE_BITS-1:0]  share_t;
	typedef logic [PERIOD_BITS-1:0] period_t;
	typedef logic [SF_BITS-1:0]     sf_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SLICE_W-1:0]     slice_t;
	typedef logic [DIV_N_W-1:0]     div_num_t;
	typedef logic [DIV_D_W-1:0]     div_den_t;
	typedef logic [DIV_CNT_W-1:0]   div_cnt_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	// register index of the unsliced period; shares sit below it
	localparam cfg_idx_t REG_PERIOD = cfg_idx_t'(NUM_SLICES);

	typedef enum logic [STATUS_W-1:0] {
		STAT_SLICE    = 2'd0,
		STAT_UNSLICED = 2'd1,
		STAT_NONE     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MOD_WAIT,
		S_PICK,
		S_OUT,
		S_GCD_LOAD,
		S_GCD_STEP,
		S_GCD_WAIT,
		S_QUO_START,
		S_QUO_WAIT
	} ctrl_state_t;

	typedef struct packed {
		logic     start;
		div_num_t dividend;
		div_den_t divisor;
	} div_req_t;

	typedef struct packed {
		logic     done;
		div_num_t quo;
		div_den_t rem;
	} div_rsp_t;

endpackage

>>> design/pssel_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pssel_pkg for widths and the request/response structs.
module pssel_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pssel_pkg::div_req_t req,
	output pssel_pkg::div_rsp_t rsp
);

	pssel_pkg::div_num_t quo_q;
	pssel_pkg::div_den_t rem_q;
	pssel_pkg::div_den_t den_q;
	pssel_pkg::div_cnt_t cnt_q;
	logic                done_q;

	logic [pssel_pkg::DIV_D_W:0] trial;
	logic [pssel_pkg::DIV_D_W:0] den_ext;
	logic [pssel_pkg::DIV_D_W:0] diff;
	logic                        fits;

	always_comb begin
		trial   = {rem_q, quo_q[pssel_pkg::DIV_N_W-1]};
		den_ext = {1'b0, den_q};
		diff    = trial - den_ext;
		fits    = (trial >= den_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else if (req.start) begin
			// a new start also aborts any division in flight
			quo_q  <= req.dividend;
			rem_q  <= '0;
			den_q  <= req.divisor;
			cnt_q  <= pssel_pkg::div_cnt_t'(pssel_pkg::DIV_N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? diff[pssel_pkg::DIV_D_W-1:0] : trial[pssel_pkg::DIV_D_W-1:0];
			quo_q  <= {quo_q[pssel_pkg::DIV_N_W-2:0], fits};
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == pssel_pkg::div_cnt_t'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

>>> design/pssel_ctrl.sv
// Sequencer: GCD reduction of the shares, cumulative bounds, per-item
// unsliced check and slice pick, plus the output register.
// Depends on pssel_pkg; drives the shared divider pssel_div.
module pssel_ctrl (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            recalc,
	input  logic [pssel_pkg::NUM_SLICES-1:0][pssel_pkg::SHARE_BITS-1:0] share,
	input  pssel_pkg::period_t                              period,
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  pssel_pkg::sf_t                                  sf,
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output logic [pssel_pkg::STATUS_W-1:0]                  status,
	output pssel_pkg::slice_t                               slice_index,
	output pssel_pkg::div_req_t                             div_req,
	input  pssel_pkg::div_rsp_t                             div_rsp
);

	pssel_pkg::ctrl_state_t state_q, state_nxt;

	pssel_pkg::idx_t   idx_q;
	pssel_pkg::share_t a_q;
	pssel_pkg::share_t b_q;
	pssel_pkg::cnt_t   acc_q;
	pssel_pkg::cnt_t   cum_q [pssel_pkg::NUM_SLICES];
	pssel_pkg::cnt_t   cursor_q;
	pssel_pkg::sf_t    sf_q;
	pssel_pkg::status_t res_status_q;
	pssel_pkg::slice_t  res_slice_q;

	logic               out_valid_q;
	pssel_pkg::status_t out_status_q;
	pssel_pkg::slice_t  out_slice_q;

	pssel_pkg::cnt_t   total;
	pssel_pkg::cnt_t   cursor_inc;
	pssel_pkg::cnt_t   cursor_nxt;
	pssel_pkg::cnt_t   quo_ext;
	pssel_pkg::slice_t chosen;
	logic              idx_last;
	logic              in_accept;
	logic              out_free;

	assign total      = cum_q[pssel_pkg::NUM_SLICES-1];
	assign idx_last   = (idx_q == pssel_pkg::idx_t'(pssel_pkg::NUM_SLICES - 1));
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign quo_ext    = pssel_pkg::cnt_t'(pssel_pkg::share_t'(div_rsp.quo));
	assign cursor_inc = cursor_q + 1'b1;
	assign cursor_nxt = (cursor_inc >= total) ? '0 : cursor_inc;

	// first slice whose cumulative bound lies above the cursor
	always_comb begin
		chosen = '0;
		for (int i = pssel_pkg::NUM_SLICES - 1; i >= 0; i--) begin
			if (cursor_q < cum_q[i]) chosen = pssel_pkg::slice_t'(i);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		if (recalc) begin
			state_nxt = pssel_pkg::S_GCD_LOAD;
		end else begin
			unique case (state_q)
				pssel_pkg::S_IDLE:
					if (in_accept) state_nxt = pssel_pkg::S_CHECK;
				pssel_pkg::S_CHECK: begin
					if (total == '0)              state_nxt = pssel_pkg::S_OUT;
					else if (period != '0)        state_nxt = pssel_pkg::S_MOD_WAIT;
					else                          state_nxt = pssel_pkg::S_PICK;
				end
				pssel_pkg::S_MOD_WAIT:
					if (div_rsp.done)
						state_nxt = (div_rsp.rem == '0) ? pssel_pkg::S_OUT : pssel_pkg::S_PICK;
				pssel_pkg::S_PICK:
					state_nxt = pssel_pkg::S_OUT;
				pssel_pkg::S_OUT:
					if (out_free) state_nxt = pssel_pkg::S_IDLE;
				pssel_pkg::S_GCD_LOAD:
					state_nxt = pssel_pkg::S_GCD_STEP;
				pssel_pkg::S_GCD_STEP: begin
					if (a_q != '0)     state_nxt = pssel_pkg::S_GCD_WAIT;
					else if (idx_last) state_nxt = pssel_pkg::S_QUO_START;
					else               state_nxt = pssel_pkg::S_GCD_LOAD;
				end
				pssel_pkg::S_GCD_WAIT:
					if (div_rsp.done) state_nxt = pssel_pkg::S_GCD_STEP;
				pssel_pkg::S_QUO_START:
					state_nxt = (b_q == '0) ? pssel_pkg::S_IDLE : pssel_pkg::S_QUO_WAIT;
				pssel_pkg::S_QUO_WAIT:
					if (div_rsp.done)
						state_nxt = idx_last ? pssel_pkg::S_IDLE : pssel_pkg::S_QUO_START;
				default:
					state_nxt = pssel_pkg::S_IDLE;
			endcase
		end
	end

	// divider requests and input stall
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = pssel_pkg::div_num_t'(sf_q);
		div_req.divisor  = pssel_pkg::div_den_t'(period);
		in_stall         = (state_q != pssel_pkg::S_IDLE) || recalc;
		unique case (state_q)
			pssel_pkg::S_CHECK:
				div_req.start = !recalc && (total != '0) && (period != '0);
			pssel_pkg::S_GCD_STEP: begin
				div_req.start    = !recalc && (a_q != '0);
				div_req.dividend = pssel_pkg::div_num_t'(b_q);
				div_req.divisor  = pssel_pkg::div_den_t'(a_q);
			end
			pssel_pkg::S_QUO_START: begin
				div_req.start    = !recalc && (b_q != '0);
				div_req.dividend = pssel_pkg::div_num_t'(share[idx_q]);
				div_req.divisor  = pssel_pkg::div_den_t'(b_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pssel_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			a_q          <= '0;
			b_q          <= '0;
			acc_q        <= '0;
			cursor_q     <= '0;
			for (int i = 0; i < pssel_pkg::NUM_SLICES; i++) cum_q[i] <= '0;
			sf_q         <= '0;
			res_status_q <= pssel_pkg::STAT_NONE;
			res_slice_q  <= '0;
		end else if (recalc) begin
			idx_q    <= '0;
			b_q      <= '0;
			cursor_q <= '0;
		end else begin
			unique case (state_q)
				pssel_pkg::S_IDLE:
					if (in_accept) sf_q <= sf;
				pssel_pkg::S_CHECK: begin
					res_status_q <= pssel_pkg::STAT_NONE;
					res_slice_q  <= '0;
				end
				pssel_pkg::S_MOD_WAIT: begin
					res_status_q <= pssel_pkg::STAT_UNSLICED;
					res_slice_q  <= '0;
				end
				pssel_pkg::S_PICK: begin
					res_status_q <= pssel_pkg::STAT_SLICE;
					res_slice_q  <= chosen;
					cursor_q     <= cursor_nxt;
				end
				pssel_pkg::S_GCD_LOAD:
					a_q <= share[idx_q];
				pssel_pkg::S_GCD_STEP:
					if (a_q == '0) begin
						// b holds the running GCD
						idx_q <= idx_last ? '0 : idx_q + 1'b1;
						acc_q <= '0;
					end
				pssel_pkg::S_GCD_WAIT:
					if (div_rsp.done) begin
						b_q <= a_q;
						a_q <= pssel_pkg::share_t'(div_rsp.rem);
					end
				pssel_pkg::S_QUO_START:
					if (b_q == '0) begin
						for (int i = 0; i < pssel_pkg::NUM_SLICES; i++) cum_q[i] <= '0;
					end
				pssel_pkg::S_QUO_WAIT:
					if (div_rsp.done) begin
						cum_q[idx_q] <= acc_q + quo_ext;
						acc_q        <= acc_q + quo_ext;
						idx_q        <= idx_last ? '0 : idx_q + 1'b1;
					end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pssel_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pssel_pkg::S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_slice_q  <= res_slice_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slice_index = out_slice_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pssel_pkg::S_IDLE && total != '0) |-> (cursor_q < total))
		else $error("cursor outside allocation sequence");

	a_pick_needs_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pssel_pkg::S_PICK) |-> (total != '0))
		else $error("slice pick with no allocation");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == pssel_pkg::S_OUT))
		else $error("result appeared outside output state");

	a_slice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != pssel_pkg::STAT_SLICE) |-> (out_slice_q == '0))
		else $error("slice index set on a non-slice result");

	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pssel_pkg::S_GCD_WAIT || state_q == pssel_pkg::S_QUO_WAIT ||
		 state_q == pssel_pkg::S_MOD_WAIT) |-> in_stall)
		else $error("input taken while the divider is busy");

endmodule

>>> design/proportional_subframe_slice_selector_core.sv
// An accepted item goes through the check, pick and output states, and the result is then held
// in the output register; with no allocation the pick is skipped, and with an unsliced period set
// the check waits on the 14-step divider. Items are taken one at a time.
// A config write to a share or the period restarts the share reduction (GCD plus quotients on the
// same divider) and holds off input items until it finishes.
// Reset: all shares and the period clear to zero, so items report no allocation.
module proportional_subframe_slice_selector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  pssel_pkg::cfg_idx_t                 cfg_index,
	input  logic [pssel_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pssel_pkg::sf_t                      subframe_number,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pssel_pkg::STATUS_W-1:0]      status,
	output pssel_pkg::slice_t                   slice_index
);

	logic [pssel_pkg::NUM_SLICES-1:0][pssel_pkg::SHARE_BITS-1:0] share_q;
	pssel_pkg::period_t  period_q;
	logic                recalc;
	pssel_pkg::div_req_t div_req;
	pssel_pkg::div_rsp_t div_rsp;

	// writes beyond the register list are dropped and trigger nothing
	assign recalc = cfg_we && (cfg_index <= pssel_pkg::REG_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_q  <= '0;
			period_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index < pssel_pkg::REG_PERIOD)
				share_q[cfg_index[pssel_pkg::IDX_W-1:0]] <= cfg_data[pssel_pkg::SHARE_BITS-1:0];
			else if (cfg_index == pssel_pkg::REG_PERIOD)
				period_q <= cfg_data[pssel_pkg::PERIOD_BITS-1:0];
		end
	end

	pssel_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pssel_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.recalc      (recalc),
		.share       (share_q),
		.period      (period_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sf          (subframe_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slice_index (slice_index),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

endmodule

>>> verif/proportional_subframe_slice_selector_core_test.sv
`timescale 1ns / 1ps
// Testbench for proportional_subframe_slice_selector_core: directed and random subframe
// items, each result checked against an in-bench slice predictor. Depends on pssel_pkg.
module proportional_subframe_slice_selector_core_test;

	localparam int ITEM_TARGET    = 1300;
	localparam int SETTLE_CYCLES  = 24;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int END_LIMIT      = 20000;
	localparam int SF_WRAP        = 10240;
	localparam int LIMIT_NS       = 12_000_000;
	localparam pssel_pkg::cfg_idx_t REG_BEYOND = pssel_pkg::REG_PERIOD + pssel_pkg::cfg_idx_t'(1);

	typedef logic [pssel_pkg::CFG_DATA_W-1:0] cfg_data_t;

	typedef struct packed {
		pssel_pkg::status_t st;
		pssel_pkg::slice_t  sl;
	} slice_decision_t;

	// Slice ownership predictor plus the queue of decisions still owed by the block.
	class slice_scoreboard;
		pssel_pkg::share_t  share [pssel_pkg::NUM_SLICES];
		pssel_pkg::period_t period;
		int                 reduced [pssel_pkg::NUM_SLICES];
		int                 total;
		int                 cursor;
		slice_decision_t    expected_q[$];
		int                 errors;
		int                 checked;
		int                 n_sliced;
		int                 n_unsliced;
		int                 n_none;

		function new();
			foreach (share[i]) share[i] = '0;
			period = '0;
			reduce_shares();
		endfunction

		// shares divided by their common gcd; cursor restarts on every share or period write
		function void reduce_shares();
			int g;
			int a;
			int b;
			int t;
			g = 0;
			foreach (share[i]) begin
				a = int'(share[i]);
				b = g;
				while (a != 0) begin
					t = b % a;
					b = a;
					a = t;
				end
				g = b;
			end
			total = 0;
			foreach (share[i]) begin
				reduced[i] = (g != 0) ? int'(share[i]) / g : 0;
				total += reduced[i];
			end
			cursor = 0;
		endfunction

		function void write_reg(pssel_pkg::cfg_idx_t idx, cfg_data_t val);
			if (idx < pssel_pkg::cfg_idx_t'(pssel_pkg::NUM_SLICES))
				share[idx[pssel_pkg::IDX_W-1:0]] = val[pssel_pkg::SHARE_BITS-1:0];
			else if (idx == pssel_pkg::REG_PERIOD)
				period = val[pssel_pkg::PERIOD_BITS-1:0];
			else
				return;
			reduce_shares();
		endfunction

		function void note_input(pssel_pkg::sf_t sf);
			slice_decision_t d;
			int acc;
			d.sl = '0;
			if (total == 0)
				d.st = pssel_pkg::STAT_NONE;
			else if (period != 0 && int'(sf) % int'(period) == 0)
				d.st = pssel_pkg::STAT_UNSLICED;
			else begin
				d.st = pssel_pkg::STAT_SLICE;
				acc = 0;
				for (int i = 0; i < pssel_pkg::NUM_SLICES; i++) begin
					acc += reduced[i];
					if (cursor < acc) begin
						d.sl = pssel_pkg::slice_t'(i);
						break;
					end
				end
				cursor = (cursor + 1 >= total) ? 0 : cursor + 1;
			end
			expected_q = {expected_q, d};
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic [pssel_pkg::STATUS_W-1:0] st, pssel_pkg::slice_t sl);
			slice_decision_t d;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result status %0d slice %0d", st, sl));
				return;
			end
			d = expected_q.pop_front();
			checked++;
			if (st !== d.st)
				report($sformatf("status %0d, expected %0d", st, d.st));
			if (sl !== d.sl)
				report($sformatf("slice_index %0d, expected %0d (status %0d)", sl, d.sl, d.st));
			case (d.st)
				pssel_pkg::STAT_SLICE:    n_sliced++;
				pssel_pkg::STAT_UNSLICED: n_unsliced++;
				default:                  n_none++;
			endcase
		endtask
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	pssel_pkg::cfg_idx_t                 cfg_index = '0;
	cfg_data_t                           cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	pssel_pkg::sf_t                      subframe_number = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [pssel_pkg::STATUS_W-1:0]      status;
	pssel_pkg::slice_t                   slice_index;

	slice_scoreboard sb = new();
	int              rx_hold_reqs = 0;
	bit              tx_steady = 1'b0;
	int              n_items = 0;
	int              n_cfg_writes = 0;

	proportional_subframe_slice_selector_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.subframe_number (subframe_number),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.slice_index     (slice_index)
	);

	always #4 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, slice_index);
	end

	// receiver: short and long stalls, quiet stretches, and one long hold on request
	initial begin
		int r;
		int len;
		int holds_done;
		holds_done = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_reqs != holds_done) begin
				holds_done = rx_hold_reqs;
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 8);
				end else if (r < 55) begin
					out_stall <= 1'b0;
					len = $urandom_range(30, 80);
				end else if (r < 92) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 4);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(15, 60);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	task automatic send_item(pssel_pkg::sf_t sf);
		int r;
		int gap;
		subframe_number <= sf;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(sf);
		n_items++;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 60)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(12, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			subframe_number <= pssel_pkg::sf_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(pssel_pkg::cfg_idx_t idx, cfg_data_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		n_cfg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int s0, int s1, int s2, int s3, int per);
		int vals [pssel_pkg::NUM_SLICES];
		vals = '{s0, s1, s2, s3};
		for (int i = 0; i < pssel_pkg::NUM_SLICES; i++)
			write_reg(pssel_pkg::cfg_idx_t'(i), cfg_data_t'(vals[i]));
		write_reg(pssel_pkg::REG_PERIOD, cfg_data_t'(per));
	endtask

	initial begin
		int phase;
		int mode;
		int fac;
		int lone;
		int val;
		int r;
		int cur_period;
		int sf_ctr;
		int n_phase_items;
		int wait_cnt;
		pssel_pkg::sf_t sf;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing configured yet: no allocation, even above the subframe range
		send_item(pssel_pkg::sf_t'(0));
		send_item(pssel_pkg::sf_t'(SF_WRAP - 1));
		send_item('1);
		wait_drained();

		// gcd of 2 gives counts 1,2,0,3; slice 2 is absent
		set_config(2, 4, 0, 6, 0);
		repeat (6) send_item(pssel_pkg::sf_t'($urandom_range(0, SF_WRAP - 1)));
		wait_drained();
		write_reg(pssel_pkg::REG_PERIOD, cfg_data_t'(10));
		send_item(pssel_pkg::sf_t'(0));
		send_item(pssel_pkg::sf_t'(5));
		send_item(pssel_pkg::sf_t'(10));
		send_item(pssel_pkg::sf_t'(7));
		wait_drained();

		// all shares zero wins over the unsliced check
		set_config(0, 0, 0, 0, 10);
		send_item(pssel_pkg::sf_t'(0));
		send_item(pssel_pkg::sf_t'(10));
		wait_drained();

		// period of one: every subframe unsliced
		set_config(0, 0, 255, 0, 1);
		send_item(pssel_pkg::sf_t'(3));
		send_item('1);
		wait_drained();

		set_config(255, 255, 255, 255, 255);
		send_item(pssel_pkg::sf_t'(255));
		send_item(pssel_pkg::sf_t'(0));
		send_item('1);
		send_item(pssel_pkg::sf_t'(254));
		wait_drained();

		// writes past the register list must not restart the cursor
		set_config(1, 1, 1, 1, 0);
		send_item(pssel_pkg::sf_t'(1));
		send_item(pssel_pkg::sf_t'(2));
		wait_drained();
		for (int idx = int'(REG_BEYOND); idx < (1 << pssel_pkg::CFG_IDX_W); idx++)
			write_reg(pssel_pkg::cfg_idx_t'(idx), '1);
		send_item(pssel_pkg::sf_t'(3));
		send_item(pssel_pkg::sf_t'(4));
		wait_drained();

		cur_period = 0;
		sf_ctr = 0;
		phase = 0;
		while (n_items < ITEM_TARGET) begin
			wait_drained();
			mode = $urandom_range(0, 9);
			fac = $urandom_range(1, 40);
			lone = $urandom_range(0, pssel_pkg::NUM_SLICES - 1);
			for (int i = 0; i < pssel_pkg::NUM_SLICES; i++) begin
				case (mode)
					3, 4: begin
						// common factor so the gcd reduction has work to do
						val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6) * fac;
						if (val > 255)
							val = fac;
					end
					5, 6: begin
						r = $urandom_range(0, 3);
						val = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 255 : 128;
					end
					7:       val = (i == lone) ? $urandom_range(1, 255) : 0;
					8:       val = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
					9:       val = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255);
					default: val = $urandom_range(0, 255);
				endcase
				if (phase == 0 || $urandom_range(0, 3) != 0)
					write_reg(pssel_pkg::cfg_idx_t'(i), cfg_data_t'(val));
			end
			r = $urandom_range(0, 19);
			if (r < 8)
				cur_period = 0;
			else if (r == 8)
				cur_period = 1;
			else if (r == 9)
				cur_period = 255;
			else if (r < 16)
				cur_period = $urandom_range(2, 15);
			else
				cur_period = $urandom_range(0, 255);
			if (phase == 0 || $urandom_range(0, 3) != 0)
				write_reg(pssel_pkg::REG_PERIOD, cfg_data_t'(cur_period));
			else
				cur_period = int'(sb.period);
			if ($urandom_range(0, 3) == 0)
				write_reg(pssel_pkg::cfg_idx_t'($urandom_range(int'(REG_BEYOND),
					(1 << pssel_pkg::CFG_IDX_W) - 1)), cfg_data_t'($urandom));

			tx_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0)
				sf_ctr = $urandom_range(0, SF_WRAP - 1);
			n_phase_items = $urandom_range(30, 90);
			for (int k = 0; k < n_phase_items; k++) begin
				// receiver holds off while items keep coming, so the input backs up
				if (phase == 1 && k == 8)
					rx_hold_reqs++;
				if (phase == 3 && k == 20)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 80) begin
					sf_ctr = (sf_ctr + 1) % SF_WRAP;
					sf = pssel_pkg::sf_t'(sf_ctr);
				end else if (r < 90 || cur_period == 0)
					sf = pssel_pkg::sf_t'($urandom);
				else
					sf = pssel_pkg::sf_t'(cur_period *
						$urandom_range(0, (SF_WRAP - 1) / cur_period));
				send_item(sf);
			end
			tx_steady = 1'b0;
			phase++;
		end

		in_valid <= 1'b0;
		wait_cnt = 0;
		while (sb.expected_q.size() != 0 && wait_cnt < END_LIMIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

		$display("Ran %0d items over %0d config phases with %0d register writes.",
			n_items, phase + 7, n_cfg_writes);
		$display("Checked %0d results: %0d sliced, %0d unsliced, %0d unallocated; %0d errors.",
			sb.checked, sb.n_sliced, sb.n_unsliced, sb.n_none, sb.errors);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
design/pssel_pkg.sv
design/pssel_div.sv
design/pssel_ctrl.sv
design/proportional_subframe_slice_selector_core.sv
verif/proportional_subframe_slice_selector_core_test.sv
